// ----- rtl/pmne_pkg.sv -----
`timescale 1ns / 1ps
package pmne_pkg;

   localparam int COORD_BITS = 21;
   localparam int POINT_W    = 63;
   localparam int POS_W      = 12;
   localparam int DIM_W      = 13;
   localparam int DIFF_W     = COORD_BITS + 1;
   localparam int PROD_W     = 2 * DIFF_W;
   localparam int CROSS_W    = PROD_W + 1;
   localparam int BL_W       = 6;
   localparam int NORM_BITS  = 30;
   localparam int SQ_W       = 2 * NORM_BITS;
   localparam int L2_W       = SQ_W + 2;
   localparam int ROOT_W     = 64;
   localparam int LEN_W      = NORM_BITS + 1;
   localparam int UNIT_FRAC  = 20;
   localparam int OUT_FRAC   = 14;
   localparam int QUO_W      = UNIT_FRAC + 1;
   localparam int REM_W      = LEN_W + QUO_W;
   localparam int UNIT_W     = UNIT_FRAC + 2;
   localparam int NTRI       = 8;
   localparam int SUM_W      = UNIT_W + 3;
   localparam int OUT_W      = 16;
   localparam int SQRT_STEPS = 32;
   localparam int NORM_DEPTH = 5 + SQRT_STEPS + 1 + QUO_W + 1;
   localparam int CROSS_DEPTH = 3;

   localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
   localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

   typedef logic [POINT_W-1:0] point_type;

   typedef struct packed {
      logic [POS_W-1:0] pixel_col;
      logic [POS_W-1:0] pixel_row;
      point_type        centre_point;
      point_type        left_point;
      point_type        up_left_point;
      point_type        up_point;
      point_type        up_right_point;
      point_type        right_point;
      point_type        down_right_point;
      point_type        down_point;
      point_type        down_left_point;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] normal_x;
      logic signed [OUT_W-1:0] normal_y;
      logic signed [OUT_W-1:0] normal_z;
      logic                    degenerate;
   } rsp_type;

   typedef logic [2:0][CROSS_W-1:0] cross_vec_type;
   typedef logic [2:0][UNIT_W-1:0]  unit_vec_type;

   typedef enum logic {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   function automatic logic signed [COORD_BITS-1:0] point_coord(point_type p, int unsigned k);
      return p[k*COORD_BITS +: COORD_BITS];
   endfunction

endpackage

// ----- rtl/point_map_normal_estimator_unit.sv -----
`timescale 1ns / 1ps
// Surface normal of one point-map pixel from its 3x3 window. Fully pipelined: a new
// window is taken every cycle unless the pipeline holds, and passes through cross
// products, per-triangle normalization, summing and final normalization. Each
// normalizer holds a 32-stage integer square root and a 21-stage restoring divider.
// When rsp_ready is low with a result waiting, the whole pipeline holds and req_ready
// drops. Image size registers are written through the csr port; the user must write
// them only while no transfer is in flight, and the block does not enforce this.
module point_map_normal_estimator_unit import pmne_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  req_type       req_payload,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type       rsp_payload,
   input  logic          csr_wr_en,
   input  csr_index_type csr_index,
   input  logic [DIM_W-1:0] csr_wr_data
);

   logic [DIM_W-1:0]  width_ff;
   logic [DIM_W-1:0]  height_ff;
   logic              advance;
   logic [DIM_W-1:0]  col13, row13;
   logic              left_ok, right_ok, up_ok, down_ok;
   point_type         tri_a [NTRI];
   point_type         tri_b [NTRI];
   logic [NTRI-1:0]   tri_use;
   logic [NTRI-1:0]   cross_valid;
   cross_vec_type     tri_cross [NTRI];
   logic [NTRI-1:0]   unit_valid;
   unit_vec_type      unit [NTRI];
   logic [NTRI-1:0]   unit_zero;
   logic [2:0][SUM_W-1:0] sum_in;
   logic [2:0][SUM_W-1:0] sum_ff;
   logic              sum_valid_ff;
   cross_vec_type     sum_ext;
   unit_vec_type      final_vec;
   logic              final_zero;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wr_data;
            CSR_IMAGE_HEIGHT: height_ff <= csr_wr_data;
            default:          width_ff  <= width_ff;
         endcase
      end
   end

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   assign col13    = DIM_W'(req_payload.pixel_col);
   assign row13    = DIM_W'(req_payload.pixel_row);
   assign left_ok  = (col13 != '0) && ((col13 - DIM_W'(1)) < width_ff);
   assign right_ok = (col13 + DIM_W'(1)) < width_ff;
   assign up_ok    = (row13 != '0) && ((row13 - DIM_W'(1)) < height_ff);
   assign down_ok  = (row13 + DIM_W'(1)) < height_ff;

   // two triangles per diagonal neighbour, walking the ring
   always_comb begin
      tri_a[0] = req_payload.up_left_point;    tri_b[0] = req_payload.left_point;
      tri_a[1] = req_payload.up_point;         tri_b[1] = req_payload.up_left_point;
      tri_a[2] = req_payload.up_right_point;   tri_b[2] = req_payload.up_point;
      tri_a[3] = req_payload.right_point;      tri_b[3] = req_payload.up_right_point;
      tri_a[4] = req_payload.down_right_point; tri_b[4] = req_payload.right_point;
      tri_a[5] = req_payload.down_point;       tri_b[5] = req_payload.down_right_point;
      tri_a[6] = req_payload.down_left_point;  tri_b[6] = req_payload.down_point;
      tri_a[7] = req_payload.left_point;       tri_b[7] = req_payload.down_left_point;
      tri_use[0] = left_ok && up_ok;
      tri_use[1] = left_ok && up_ok;
      tri_use[2] = right_ok && up_ok;
      tri_use[3] = right_ok && up_ok;
      tri_use[4] = right_ok && down_ok;
      tri_use[5] = right_ok && down_ok;
      tri_use[6] = left_ok && down_ok;
      tri_use[7] = left_ok && down_ok;
   end

   for (genvar t = 0; t < NTRI; t++) begin : g_tri
      pmne_cross u_cross (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (req_valid && req_ready),
         .use_tri   (tri_use[t]),
         .centre    (req_payload.centre_point),
         .point_a   (tri_a[t]),
         .point_b   (tri_b[t]),
         .out_valid (cross_valid[t]),
         .cross_out (tri_cross[t])
      );

      pmne_norm u_norm (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .in_valid   (cross_valid[t]),
         .short_frac (1'b0),
         .in_vec     (tri_cross[t]),
         .out_valid  (unit_valid[t]),
         .out_vec    (unit[t]),
         .out_zero   (unit_zero[t])
      );
   end

   // zero triangle normals come out as zero vectors, so a plain sum is enough
   always_comb begin
      sum_in = '0;
      for (int t = 0; t < NTRI; t++) begin
         for (int i = 0; i < 3; i++) begin
            sum_in[i] = SUM_W'($signed(sum_in[i]) + $signed(unit[t][i]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
      end else if (advance) begin
         sum_valid_ff <= unit_valid[0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sum_ff <= sum_in;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sum_ext[i] = CROSS_W'($signed(sum_ff[i]));
      end
   end

   pmne_norm u_final (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (sum_valid_ff),
      .short_frac (1'b1),
      .in_vec     (sum_ext),
      .out_valid  (rsp_valid),
      .out_vec    (final_vec),
      .out_zero   (final_zero)
   );

   assign rsp_payload.normal_x   = final_vec[0][OUT_W-1:0];
   assign rsp_payload.normal_y   = final_vec[1][OUT_W-1:0];
   assign rsp_payload.normal_z   = final_vec[2][OUT_W-1:0];
   assign rsp_payload.degenerate = final_zero;

   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.degenerate |->
         rsp_payload.normal_x == '0 && rsp_payload.normal_y == '0 &&
         rsp_payload.normal_z == '0)
      else $error("degenerate result with nonzero components");

   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         $signed(rsp_payload.normal_x) <= 16384 && $signed(rsp_payload.normal_x) >= -16384 &&
         $signed(rsp_payload.normal_y) <= 16384 && $signed(rsp_payload.normal_y) >= -16384 &&
         $signed(rsp_payload.normal_z) <= 16384 && $signed(rsp_payload.normal_z) >= -16384)
      else $error("normal component out of unit range");

   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      (unit_valid == '0) || (unit_valid == '1))
      else $error("triangle lanes out of step");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_lane_zero_value: assert property (@(posedge clock) disable iff (reset)
      unit_valid[0] && unit_zero[0] |-> unit[0] == '0)
      else $error("zero triangle normal carries a value");

endmodule

// ----- rtl/pmne_cross.sv -----
`timescale 1ns / 1ps
module pmne_cross import pmne_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic          in_valid,
   input  logic          use_tri,
   input  point_type     centre,
   input  point_type     point_a,
   input  point_type     point_b,
   output logic          out_valid,
   output cross_vec_type cross_out
);

   logic [CROSS_DEPTH-1:0]          vld_ff;
   logic [2:0][DIFF_W-1:0]          e1_ff;
   logic [2:0][DIFF_W-1:0]          e2_ff;
   logic                            use1_ff;
   logic                            use2_ff;
   logic [5:0][PROD_W-1:0]          prod_ff;
   cross_vec_type                   cross_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[CROSS_DEPTH-2:0], in_valid};
      end
   end

   // edge vectors from the centre point
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            e1_ff[i] <= DIFF_W'($signed(point_coord(point_a, i)) -
                                $signed(point_coord(centre, i)));
            e2_ff[i] <= DIFF_W'($signed(point_coord(point_b, i)) -
                                $signed(point_coord(centre, i)));
         end
         use1_ff <= use_tri;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff[0] <= PROD_W'($signed(e1_ff[1]) * $signed(e2_ff[2]));
         prod_ff[1] <= PROD_W'($signed(e1_ff[2]) * $signed(e2_ff[1]));
         prod_ff[2] <= PROD_W'($signed(e1_ff[2]) * $signed(e2_ff[0]));
         prod_ff[3] <= PROD_W'($signed(e1_ff[0]) * $signed(e2_ff[2]));
         prod_ff[4] <= PROD_W'($signed(e1_ff[0]) * $signed(e2_ff[1]));
         prod_ff[5] <= PROD_W'($signed(e1_ff[1]) * $signed(e2_ff[0]));
         use2_ff    <= use1_ff;
      end
   end

   // a triangle that does not count is sent on as a zero vector
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            cross_ff[i] <= use2_ff ?
               CROSS_W'($signed(prod_ff[2*i]) - $signed(prod_ff[2*i+1])) : '0;
         end
      end
   end

   assign out_valid = vld_ff[CROSS_DEPTH-1];
   assign cross_out = cross_ff;

endmodule

// ----- rtl/pmne_norm.sv -----
`timescale 1ns / 1ps
module pmne_norm import pmne_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic          in_valid,
   input  logic          short_frac,
   input  cross_vec_type in_vec,
   output logic          out_valid,
   output unit_vec_type  out_vec,
   output logic          out_zero
);

   typedef struct packed {
      logic [2:0][NORM_BITS-1:0] r;
      logic [2:0]                neg;
      logic                      zero;
   } side_type;

   logic [NORM_DEPTH-1:0]       vld_ff;
   logic [2:0][CROSS_W-1:0]     mag_ff;
   logic [2:0]                  neg1_ff;
   logic [2:0][CROSS_W-1:0]     mag2_ff;
   logic [2:0]                  neg2_ff;
   logic [BL_W-1:0]             bl_ff;
   logic                        zero2_ff;
   side_type                    side3_ff;
   side_type                    side4_ff;
   logic [2:0][SQ_W-1:0]        sq_ff;
   logic [CROSS_W-1:0]          or_in;
   logic [BL_W-1:0]             bl_in;

   logic [ROOT_W-1:0]           sq_v_ff   [0:SQRT_STEPS];
   logic [ROOT_W-1:0]           sq_res_ff [0:SQRT_STEPS];
   side_type                    sq_side_ff[0:SQRT_STEPS];

   logic [2:0][REM_W-1:0]       dv_rem_ff [0:QUO_W];
   logic [2:0][QUO_W-1:0]       dv_q_ff   [0:QUO_W];
   logic [LEN_W-1:0]            dv_den_ff [0:QUO_W];
   logic [2:0]                  dv_neg_ff [0:QUO_W];
   logic                        dv_zero_ff[0:QUO_W];

   unit_vec_type                out_vec_ff;
   logic                        out_zero_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[NORM_DEPTH-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            neg1_ff[i] <= in_vec[i][CROSS_W-1];
            mag_ff[i]  <= in_vec[i][CROSS_W-1] ? (~in_vec[i] + CROSS_W'(1)) : in_vec[i];
         end
      end
   end

   // the top bit of the largest magnitude is the top bit of the or of all three
   always_comb begin
      or_in = mag_ff[0] | mag_ff[1] | mag_ff[2];
      bl_in = '0;
      for (int i = 0; i < CROSS_W; i++) begin
         if (or_in[i]) bl_in = BL_W'(i + 1);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mag2_ff  <= mag_ff;
         neg2_ff  <= neg1_ff;
         bl_ff    <= bl_in;
         zero2_ff <= (or_in == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            if (bl_ff > BL_W'(NORM_BITS)) begin
               side3_ff.r[i] <= NORM_BITS'(mag2_ff[i] >> (bl_ff - BL_W'(NORM_BITS)));
            end else begin
               side3_ff.r[i] <= NORM_BITS'(mag2_ff[i] << (BL_W'(NORM_BITS) - bl_ff));
            end
         end
         side3_ff.neg  <= neg2_ff;
         side3_ff.zero <= zero2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= SQ_W'(side3_ff.r[i]) * SQ_W'(side3_ff.r[i]);
         end
         side4_ff <= side3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sq_v_ff[0]    <= ROOT_W'(sq_ff[0]) + ROOT_W'(sq_ff[1]) + ROOT_W'(sq_ff[2]);
         sq_res_ff[0]  <= '0;
         sq_side_ff[0] <= side4_ff;
      end
   end

   // integer square root, one result bit per stage
   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
      localparam logic [ROOT_W-1:0] RBIT = ROOT_W'(1) << (L2_W - 2 * j);
      logic [ROOT_W-1:0] trial;
      assign trial = sq_res_ff[j] + RBIT;
      always_ff @(posedge clock) begin
         if (advance) begin
            if (sq_v_ff[j] >= trial) begin
               sq_v_ff[j+1]   <= sq_v_ff[j] - trial;
               sq_res_ff[j+1] <= (sq_res_ff[j] >> 1) + RBIT;
            end else begin
               sq_v_ff[j+1]   <= sq_v_ff[j];
               sq_res_ff[j+1] <= sq_res_ff[j] >> 1;
            end
            sq_side_ff[j+1] <= sq_side_ff[j];
         end
      end
   end

   // dividend carries the rounding half of the length
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            dv_rem_ff[0][i] <= (REM_W'(sq_side_ff[SQRT_STEPS].r[i]) <<
                                (short_frac ? OUT_FRAC : UNIT_FRAC)) +
                               REM_W'(sq_res_ff[SQRT_STEPS][LEN_W-1:1]);
         end
         dv_q_ff[0]    <= '0;
         dv_den_ff[0]  <= sq_res_ff[SQRT_STEPS][LEN_W-1:0];
         dv_neg_ff[0]  <= sq_side_ff[SQRT_STEPS].neg;
         dv_zero_ff[0] <= sq_side_ff[SQRT_STEPS].zero;
      end
   end

   // restoring division, one quotient bit per stage, msb first
   for (genvar s = 0; s < QUO_W; s++) begin : g_div
      localparam int QB = QUO_W - 1 - s;
      logic [REM_W-1:0] dsh;
      assign dsh = REM_W'(dv_den_ff[s]) << QB;
      always_ff @(posedge clock) begin
         if (advance) begin
            for (int i = 0; i < 3; i++) begin
               if (dv_rem_ff[s][i] >= dsh) begin
                  dv_rem_ff[s+1][i]   <= dv_rem_ff[s][i] - dsh;
                  dv_q_ff[s+1][i]     <= dv_q_ff[s][i] | (QUO_W'(1) << QB);
               end else begin
                  dv_rem_ff[s+1][i]   <= dv_rem_ff[s][i];
                  dv_q_ff[s+1][i]     <= dv_q_ff[s][i];
               end
            end
            dv_den_ff[s+1]  <= dv_den_ff[s];
            dv_neg_ff[s+1]  <= dv_neg_ff[s];
            dv_zero_ff[s+1] <= dv_zero_ff[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            if (dv_zero_ff[QUO_W]) begin
               out_vec_ff[i] <= '0;
            end else if (dv_neg_ff[QUO_W][i]) begin
               out_vec_ff[i] <= UNIT_W'(0) - UNIT_W'(dv_q_ff[QUO_W][i]);
            end else begin
               out_vec_ff[i] <= UNIT_W'(dv_q_ff[QUO_W][i]);
            end
         end
         out_zero_ff <= dv_zero_ff[QUO_W];
      end
   end

   assign out_valid = vld_ff[NORM_DEPTH-1];
   assign out_vec   = out_vec_ff;
   assign out_zero  = out_zero_ff;

endmodule
